// ----- rtl/dqrr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqrr_pkg
// Shared types and constants of the two-class round-robin run queue.
// ----------------------------------------------------------------------------
package dqrr_pkg;

  // default table and deque depth
  localparam int NUM_TASKS_DEFAULT = 64;

  localparam int TASK_ID_W = 6;
  localparam int QUANTUM_W = 8;
  localparam int KIND_W    = 3;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register indexes
  localparam logic REG_QUANTUM_INTERACTIVE = 1'b0;
  localparam logic REG_QUANTUM_CPU_BOUND   = 1'b1;

  // register reset values
  localparam logic [QUANTUM_W-1:0] QUANTUM_INTERACTIVE_RST = 8'd2;
  localparam logic [QUANTUM_W-1:0] QUANTUM_CPU_BOUND_RST   = 8'd4;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_NEW     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ENQUEUE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PICK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STEAL   = 3'd4;

  // deque selector in the queue memory
  localparam logic CLS_INTERACTIVE = 1'b0;
  localparam logic CLS_CPU_BOUND   = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [TASK_ID_W-1:0] task_id;
    logic                 task_is_idle;
    logic                 task_already_queued;
  } sched_cmd_t;

  typedef struct packed {
    logic [TASK_ID_W-1:0] chosen_task;
    logic                 chosen_valid;
    logic                 resched_request;
  } sched_result_t;

  // one entry of the per-task table
  typedef struct packed {
    logic                 batch;
    logic [QUANTUM_W-1:0] slice_left;
  } task_entry_t;

endpackage : dqrr_pkg
`default_nettype wire

// ----- rtl/dqrr_task_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqrr_task_table
// Per-task class bit and remaining slice, one read and one write port,
// registered read data.
// ----------------------------------------------------------------------------
module dqrr_task_table #(
  parameter int NUM_TASKS = dqrr_pkg::NUM_TASKS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          re,
  input  wire logic [$clog2(NUM_TASKS)-1:0]  raddr,
  output      dqrr_pkg::task_entry_t         rdata,
  input  wire logic                          we,
  input  wire logic [$clog2(NUM_TASKS)-1:0]  waddr,
  input  wire dqrr_pkg::task_entry_t         wdata
);

  dqrr_pkg::task_entry_t mem [NUM_TASKS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : dqrr_task_table
`default_nettype wire

// ----- rtl/dqrr_queue_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqrr_queue_ram
// Slots of both deques in one memory: the top address bit selects the
// deque, the rest is the ring slot.
// ----------------------------------------------------------------------------
module dqrr_queue_ram #(
  parameter int NUM_TASKS = dqrr_pkg::NUM_TASKS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               re,
  input  wire logic [$clog2(NUM_TASKS):0]         raddr,
  output      logic [dqrr_pkg::TASK_ID_W-1:0]     rdata,
  input  wire logic                               we,
  input  wire logic [$clog2(NUM_TASKS):0]         waddr,
  input  wire logic [dqrr_pkg::TASK_ID_W-1:0]     wdata
);

  // deque select sits above the full slot index, so size by address width
  logic [dqrr_pkg::TASK_ID_W-1:0] mem [2**($clog2(NUM_TASKS)+1)];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : dqrr_queue_ram
`default_nettype wire

// ----- rtl/dqrr_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqrr_seq
// Two-step sequencer: on accept it reads the task table and the deque
// slot, in the next cycle it updates pointers, writes back and emits the
// result item.
// ----------------------------------------------------------------------------
module dqrr_seq #(
  parameter int NUM_TASKS = dqrr_pkg::NUM_TASKS_DEFAULT,
  localparam int IDX_W    = $clog2(NUM_TASKS),
  localparam int CNT_W    = $clog2(NUM_TASKS + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire dqrr_pkg::sched_cmd_t                request,
  output      logic                                busy,
  output      logic                                done,
  output      dqrr_pkg::sched_result_t             result,
  input  wire logic [dqrr_pkg::QUANTUM_W-1:0]      quantum_interactive,
  input  wire logic [dqrr_pkg::QUANTUM_W-1:0]      quantum_cpu_bound,
  // task table
  output      logic                                tt_re,
  output      logic [IDX_W-1:0]                    tt_raddr,
  input  wire dqrr_pkg::task_entry_t               tt_rdata,
  output      logic                                tt_we,
  output      logic [IDX_W-1:0]                    tt_waddr,
  output      dqrr_pkg::task_entry_t               tt_wdata,
  // queue memory
  output      logic                                qr_re,
  output      logic [IDX_W:0]                      qr_raddr,
  input  wire logic [dqrr_pkg::TASK_ID_W-1:0]      qr_rdata,
  output      logic                                qr_we,
  output      logic [IDX_W:0]                      qr_waddr,
  output      logic [dqrr_pkg::TASK_ID_W-1:0]      qr_wdata
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  localparam int EXT_W = IDX_W + dqrr_pkg::TASK_ID_W;

  // ring slot arithmetic, offset never exceeds the depth
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(NUM_TASKS)) begin
      sum = sum - (CNT_W+1)'(NUM_TASKS);
    end
    return sum[IDX_W-1:0];
  endfunction

  state_t               state;
  dqrr_pkg::sched_cmd_t cmd;
  logic                 in_table;
  logic [IDX_W-1:0]     tidx;
  logic                 pop_valid;
  logic                 pop_cls;
  logic [IDX_W-1:0]     head_i;
  logic [IDX_W-1:0]     head_c;
  logic [CNT_W-1:0]     cnt_i;
  logic [CNT_W-1:0]     cnt_c;

  logic                 accept;
  logic [EXT_W-1:0]     id_ext;
  logic                 in_table_next;
  logic                 pop_valid_next;
  logic                 pop_cls_next;
  logic [IDX_W-1:0]     pop_slot_next;
  logic                 is_pick;
  logic                 is_steal;

  logic                 enq_ok;
  logic                 enq_cls;
  logic                 enq_room;
  logic [IDX_W-1:0]     push_slot;
  logic                 tick_ok;
  logic [dqrr_pkg::QUANTUM_W-1:0] slice_dec;

  assign busy   = (state == ST_EXEC);
  assign done   = (state == ST_EXEC);
  assign accept = start && !busy;

  // task index and table range
  assign id_ext        = EXT_W'(request.task_id);
  assign in_table_next = (id_ext < EXT_W'(NUM_TASKS));

  // pop selection, taken from the pointers at accept time
  assign is_pick  = (request.kind == dqrr_pkg::KIND_PICK);
  assign is_steal = (request.kind == dqrr_pkg::KIND_STEAL);

  always_comb begin
    pop_valid_next = 1'b0;
    pop_cls_next   = dqrr_pkg::CLS_INTERACTIVE;
    pop_slot_next  = head_i;
    if (is_pick) begin
      if (cnt_i != '0) begin
        pop_valid_next = 1'b1;
        pop_cls_next   = dqrr_pkg::CLS_INTERACTIVE;
        pop_slot_next  = head_i;
      end else if (cnt_c != '0) begin
        pop_valid_next = 1'b1;
        pop_cls_next   = dqrr_pkg::CLS_CPU_BOUND;
        pop_slot_next  = head_c;
      end
    end else if (is_steal) begin
      if (cnt_c != '0) begin
        pop_valid_next = 1'b1;
        pop_cls_next   = dqrr_pkg::CLS_CPU_BOUND;
        pop_slot_next  = ring_add(head_c, cnt_c - CNT_W'(1));
      end else if (cnt_i != '0) begin
        pop_valid_next = 1'b1;
        pop_cls_next   = dqrr_pkg::CLS_INTERACTIVE;
        pop_slot_next  = ring_add(head_i, cnt_i - CNT_W'(1));
      end
    end
  end

  // memory reads issued on accept
  assign tt_re    = accept;
  assign tt_raddr = id_ext[IDX_W-1:0];
  assign qr_re    = accept;
  assign qr_raddr = {pop_cls_next, pop_slot_next};

  // enqueue decision from the class read back
  assign enq_ok    = (cmd.kind == dqrr_pkg::KIND_ENQUEUE) && in_table &&
                     !cmd.task_is_idle && !cmd.task_already_queued;
  assign enq_cls   = tt_rdata.batch;
  assign enq_room  = enq_cls ? (cnt_c != CNT_W'(NUM_TASKS)) : (cnt_i != CNT_W'(NUM_TASKS));
  assign push_slot = enq_cls ? ring_add(head_c, cnt_c) : ring_add(head_i, cnt_i);

  // tick charge, saturating at zero
  assign tick_ok   = (cmd.kind == dqrr_pkg::KIND_TICK) && in_table && !cmd.task_is_idle;
  assign slice_dec = (tt_rdata.slice_left != '0) ?
                     tt_rdata.slice_left - dqrr_pkg::QUANTUM_W'(1) : '0;

  // table write-back
  always_comb begin
    tt_we    = 1'b0;
    tt_waddr = tidx;
    tt_wdata = '0;
    if (busy) begin
      case (cmd.kind)
        dqrr_pkg::KIND_NEW: begin
          tt_we    = in_table;
          tt_wdata = '{batch: 1'b0, slice_left: quantum_interactive};
        end
        dqrr_pkg::KIND_ENQUEUE: begin
          tt_we    = enq_ok && enq_room;
          tt_wdata = '{batch: enq_cls,
                       slice_left: enq_cls ? quantum_cpu_bound : quantum_interactive};
        end
        dqrr_pkg::KIND_TICK: begin
          tt_we    = tick_ok;
          tt_wdata = '{batch: (slice_dec == '0), slice_left: slice_dec};
        end
        default: begin
          tt_we = 1'b0;
        end
      endcase
    end
  end

  // deque slot write for enqueue
  assign qr_we    = busy && enq_ok && enq_room;
  assign qr_waddr = {enq_cls, push_slot};
  assign qr_wdata = cmd.task_id;

  // result item
  assign result.chosen_task     = pop_valid ? qr_rdata : '0;
  assign result.chosen_valid    = pop_valid;
  assign result.resched_request = tick_ok && (slice_dec == '0);

  // state, command latch and deque pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pop_valid <= 1'b0;
      head_i    <= '0;
      head_c    <= '0;
      cnt_i     <= '0;
      cnt_c     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state     <= ST_EXEC;
            cmd       <= request;
            in_table  <= in_table_next;
            tidx      <= id_ext[IDX_W-1:0];
            pop_valid <= pop_valid_next;
            pop_cls   <= pop_cls_next;
          end
        end
        ST_EXEC: begin
          state     <= ST_IDLE;
          pop_valid <= 1'b0;
          if (pop_valid) begin
            if (pop_cls == dqrr_pkg::CLS_CPU_BOUND) begin
              cnt_c <= cnt_c - CNT_W'(1);
              if (cmd.kind == dqrr_pkg::KIND_PICK) begin
                head_c <= ring_add(head_c, CNT_W'(1));
              end
            end else begin
              cnt_i <= cnt_i - CNT_W'(1);
              if (cmd.kind == dqrr_pkg::KIND_PICK) begin
                head_i <= ring_add(head_i, CNT_W'(1));
              end
            end
          end
          if (enq_ok && enq_room) begin
            if (enq_cls) begin
              cnt_c <= cnt_c + CNT_W'(1);
            end else begin
              cnt_i <= cnt_i + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule : dqrr_seq
`default_nettype wire

// ----- rtl/dual_queue_round_robin_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dual_queue_round_robin_scheduler
// Two-class round-robin run queue with per-task slice accounting.
// ----------------------------------------------------------------------------
// Start is accepted while busy is low, busy is high in the following cycle,
// and in that same cycle done pulses for one cycle with the result item; a
// new item can start the cycle after. The registered reads of the task
// table and deque memory come first, then the write-back. The receiver
// cannot stall: chosen_task and chosen_valid clear when done falls, but
// resched_request can stay set. The user must write the quantum registers
// through the APB port while the block is idle, which is not enforced.
module dual_queue_round_robin_scheduler #(
  parameter int NUM_TASKS = dqrr_pkg::NUM_TASKS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command channel
  input  wire logic                              start,
  input  wire dqrr_pkg::sched_cmd_t              request,
  output      logic                              busy,
  output      logic                              done,
  output      dqrr_pkg::sched_result_t           result,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dqrr_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [dqrr_pkg::APB_DATA_W-1:0]   pwdata,
  output      logic [dqrr_pkg::APB_DATA_W-1:0]   prdata,
  output      logic                              pready
);

  localparam int IDX_W = $clog2(NUM_TASKS);

  logic [dqrr_pkg::QUANTUM_W-1:0] quantum_interactive;
  logic [dqrr_pkg::QUANTUM_W-1:0] quantum_cpu_bound;
  logic                           reg_sel;
  logic                           cfg_write;

  logic                           tt_re;
  logic [IDX_W-1:0]               tt_raddr;
  dqrr_pkg::task_entry_t          tt_rdata;
  logic                           tt_we;
  logic [IDX_W-1:0]               tt_waddr;
  dqrr_pkg::task_entry_t          tt_wdata;
  logic                           qr_re;
  logic [IDX_W:0]                 qr_raddr;
  logic [dqrr_pkg::TASK_ID_W-1:0] qr_rdata;
  logic                           qr_we;
  logic [IDX_W:0]                 qr_waddr;
  logic [dqrr_pkg::TASK_ID_W-1:0] qr_wdata;

  // quantum registers
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_interactive <= dqrr_pkg::QUANTUM_INTERACTIVE_RST;
      quantum_cpu_bound   <= dqrr_pkg::QUANTUM_CPU_BOUND_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        dqrr_pkg::REG_QUANTUM_INTERACTIVE: quantum_interactive <= pwdata[7:0];
        dqrr_pkg::REG_QUANTUM_CPU_BOUND:   quantum_cpu_bound   <= pwdata[7:0];
        default: begin
          quantum_interactive <= quantum_interactive;
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      dqrr_pkg::REG_QUANTUM_INTERACTIVE:
        prdata = dqrr_pkg::APB_DATA_W'(quantum_interactive);
      dqrr_pkg::REG_QUANTUM_CPU_BOUND:
        prdata = dqrr_pkg::APB_DATA_W'(quantum_cpu_bound);
      default:
        prdata = '0;
    endcase
  end

  // sequencer
  dqrr_seq #(
    .NUM_TASKS(NUM_TASKS)
  ) u_seq (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .request             (request),
    .busy                (busy),
    .done                (done),
    .result              (result),
    .quantum_interactive (quantum_interactive),
    .quantum_cpu_bound   (quantum_cpu_bound),
    .tt_re               (tt_re),
    .tt_raddr            (tt_raddr),
    .tt_rdata            (tt_rdata),
    .tt_we               (tt_we),
    .tt_waddr            (tt_waddr),
    .tt_wdata            (tt_wdata),
    .qr_re               (qr_re),
    .qr_raddr            (qr_raddr),
    .qr_rdata            (qr_rdata),
    .qr_we               (qr_we),
    .qr_waddr            (qr_waddr),
    .qr_wdata            (qr_wdata)
  );

  // per-task table
  dqrr_task_table #(
    .NUM_TASKS(NUM_TASKS)
  ) u_task_table (
    .clk   (clk),
    .re    (tt_re),
    .raddr (tt_raddr),
    .rdata (tt_rdata),
    .we    (tt_we),
    .waddr (tt_waddr),
    .wdata (tt_wdata)
  );

  // deque slots
  dqrr_queue_ram #(
    .NUM_TASKS(NUM_TASKS)
  ) u_queue_ram (
    .clk   (clk),
    .re    (qr_re),
    .raddr (qr_raddr),
    .rdata (qr_rdata),
    .we    (qr_we),
    .waddr (qr_waddr),
    .wdata (qr_wdata)
  );

endmodule : dual_queue_round_robin_scheduler
`default_nettype wire
